[hw/rtl/dpgd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpgd_pkg
// Shared widths, register indexes, reset values and structs of the depth
// push gesture detector.
// ----------------------------------------------------------------------------
package dpgd_pkg;

    // Field widths.
    localparam int unsigned DepthW   = 11;
    localparam int unsigned PixW     = 19;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned WeightW  = 16;
    localparam int unsigned FracW    = 16;
    localparam int unsigned BaseW    = DepthW + FracW;
    localparam int unsigned DeltaW   = 12;
    localparam int unsigned CountW   = 16;
    localparam int unsigned CfgDataW = 19;
    localparam int unsigned CfgIdxW  = 3;

    // Register indexes.
    localparam logic [CfgIdxW-1:0] RegWeightArmed    = 3'd0;
    localparam logic [CfgIdxW-1:0] RegWeightDisarmed = 3'd1;
    localparam logic [CfgIdxW-1:0] RegTriggerLevel   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegRearmLevel     = 3'd3;
    localparam logic [CfgIdxW-1:0] RegMinBlobPixels  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegCooldownMs     = 3'd5;

    // Register reset values.
    localparam logic [WeightW-1:0] WeightArmedRst    = 16'd2621;
    localparam logic [WeightW-1:0] WeightDisarmedRst = 16'd11796;
    localparam logic [DepthW-1:0]  TriggerLevelRst   = 11'd95;
    localparam logic [DepthW-1:0]  RearmLevelRst     = 11'd35;
    localparam logic [PixW-1:0]    MinBlobPixelsRst  = 19'd300;
    localparam logic [WeightW-1:0] CooldownMsRst     = 16'd350;

    // Configuration register set.
    typedef struct packed {
        logic [WeightW-1:0] weight_armed;
        logic [WeightW-1:0] weight_disarmed;
        logic [DepthW-1:0]  trigger_level;
        logic [DepthW-1:0]  rearm_level;
        logic [PixW-1:0]    min_blob_pixels;
        logic [WeightW-1:0] cooldown_ms;
    } cfg_t;

    // Tracker state carried from frame to frame.
    typedef struct packed {
        logic [BaseW-1:0]  baseline;
        logic              seeded;
        logic              armed;
        logic [CountW-1:0] click_total;
        logic [TimeW-1:0]  last_click_ms;
    } track_t;

    // Result of one frame.
    typedef struct packed {
        logic              clicked;
        logic [DeltaW-1:0] push_delta;
        logic              is_armed;
        logic [CountW-1:0] clicks_so_far;
    } result_t;

endpackage : dpgd_pkg
`default_nettype wire

[hw/rtl/dpgd_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpgd_update
// Per-frame update: baseline averaging, delta, click and rearm decisions.
// Purely combinational; the caller registers state and result.
// ----------------------------------------------------------------------------
module dpgd_update (
    input  wire dpgd_pkg::cfg_t                  cfg,
    input  wire dpgd_pkg::track_t                cur,
    input  wire                                  blob_present,
    input  wire [dpgd_pkg::DepthW-1:0]           near_depth,
    input  wire [dpgd_pkg::PixW-1:0]             blob_pixels,
    input  wire [dpgd_pkg::TimeW-1:0]            now_ms,
    output dpgd_pkg::track_t                     nxt,
    output dpgd_pkg::result_t                    res
);
    import dpgd_pkg::*;

    localparam int unsigned DiffW = BaseW + 1;
    localparam int unsigned ProdW = DiffW + WeightW + 1;

    logic [BaseW-1:0]          depth_q;
    logic [BaseW-1:0]          base_eff;
    logic [WeightW-1:0]        weight;
    logic signed [DiffW-1:0]   diff;
    logic signed [ProdW-1:0]   prod;
    logic signed [ProdW-1:0]   step;
    logic signed [DiffW-1:0]   base_sum;
    logic [BaseW-1:0]          base_new;
    logic signed [DiffW-1:0]   delta_q;
    logic signed [DiffW-1:0]   delta_rnd;
    logic signed [DiffW-1:0]   trig_q;
    logic signed [DiffW-1:0]   rearm_q;
    logic [TimeW-1:0]          elapsed;
    logic                      fire;

    always_comb begin
        depth_q  = {near_depth, {FracW{1'b0}}};
        // The first frame after a gap seeds the baseline from the depth.
        base_eff = cur.seeded ? cur.baseline : depth_q;
        weight   = cur.armed ? cfg.weight_armed : cfg.weight_disarmed;

        // base*(1-w) + depth*w equals base + (depth-base)*w, rounded half up.
        diff     = $signed({1'b0, depth_q}) - $signed({1'b0, base_eff});
        prod     = ProdW'(diff) * $signed({1'b0, weight});
        step     = (prod + ProdW'(32'sd32768)) >>> FracW;
        base_sum = $signed({1'b0, base_eff}) + step[DiffW-1:0];
        base_new = base_sum[BaseW-1:0];

        delta_q  = $signed({1'b0, base_new}) - $signed({1'b0, depth_q});
        trig_q   = $signed({1'b0, cfg.trigger_level, {FracW{1'b0}}});
        rearm_q  = $signed({1'b0, cfg.rearm_level, {FracW{1'b0}}});

        // Integer part truncated toward zero.
        delta_rnd = delta_q[DiffW-1] ? (delta_q + DiffW'({FracW{1'b1}})) : delta_q;

        elapsed  = now_ms - cur.last_click_ms;
        fire     = cur.armed && (elapsed > TimeW'(cfg.cooldown_ms)) &&
                   (delta_q > trig_q) && (blob_pixels > cfg.min_blob_pixels);

        nxt = cur;
        res = '0;
        if (!blob_present) begin
            // No blob: drop the seed, re-arm, report zero delta.
            nxt.seeded = 1'b0;
            nxt.armed  = 1'b1;
        end else begin
            nxt.baseline = base_new;
            nxt.seeded   = 1'b1;
            if (fire) begin
                nxt.armed         = 1'b0;
                nxt.last_click_ms = now_ms;
                nxt.click_total   = cur.click_total + CountW'(1);
            end else if (!cur.armed && (delta_q < rearm_q)) begin
                nxt.armed = 1'b1;
            end
            res.clicked    = fire;
            res.push_delta = delta_rnd[DiffW-1:FracW];
        end
        res.is_armed      = nxt.armed;
        res.clicks_so_far = nxt.click_total;
    end

endmodule : dpgd_update
`default_nettype wire

[hw/rtl/depth_push_gesture_detector_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// depth_push_gesture_detector_unit
// Detects a push gesture from per-frame depth blob summaries and counts
// clicks, tracking a Q11.16 baseline with an exponential average.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Contents
//   s_*       in         s_valid / s_ready    one frame summary
//   m_*       out        m_valid / m_ready    one frame result
//   cfg_*     in         cfg_wr_en            register index and data
//
// Each transfer is captured in an input register; from there the update
// logic (one 28x17 multiply, adds and compares) loads the result register
// and the tracker state together, and one frame is taken per cycle while
// the result register is not stalled. A stalled result register holds the
// input register, and s_ready then falls. Reset is synchronous and active
// low; it restores the register defaults, empties both registers and arms the tracker.
// ----------------------------------------------------------------------------
module depth_push_gesture_detector_unit (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Input frame channel.
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_blob_present,
    input  wire [dpgd_pkg::DepthW-1:0]       s_near_depth,
    input  wire [dpgd_pkg::PixW-1:0]         s_blob_pixels,
    input  wire [dpgd_pkg::TimeW-1:0]        s_now_ms,
    // Result channel.
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_clicked,
    output logic signed [dpgd_pkg::DeltaW-1:0] m_push_delta,
    output logic                             m_is_armed,
    output logic [dpgd_pkg::CountW-1:0]      m_clicks_so_far,
    // Configuration write port.
    input  wire                              cfg_wr_en,
    input  wire [dpgd_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire [dpgd_pkg::CfgDataW-1:0]     cfg_data
);
    import dpgd_pkg::*;

    cfg_t              cfg_reg;
    track_t            track_reg;
    track_t            track_next;
    result_t           res_next;
    result_t           res_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              in_blob_present_reg;
    logic [DepthW-1:0] in_near_depth_reg;
    logic [PixW-1:0]   in_blob_pixels_reg;
    logic [TimeW-1:0]  in_now_ms_reg;
    logic              advance;

    // The result register is free when empty or being taken this cycle.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.weight_armed    <= WeightArmedRst;
            cfg_reg.weight_disarmed <= WeightDisarmedRst;
            cfg_reg.trigger_level   <= TriggerLevelRst;
            cfg_reg.rearm_level     <= RearmLevelRst;
            cfg_reg.min_blob_pixels <= MinBlobPixelsRst;
            cfg_reg.cooldown_ms     <= CooldownMsRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                RegWeightArmed:    cfg_reg.weight_armed    <= cfg_data[WeightW-1:0];
                RegWeightDisarmed: cfg_reg.weight_disarmed <= cfg_data[WeightW-1:0];
                RegTriggerLevel:   cfg_reg.trigger_level   <= cfg_data[DepthW-1:0];
                RegRearmLevel:     cfg_reg.rearm_level     <= cfg_data[DepthW-1:0];
                RegMinBlobPixels:  cfg_reg.min_blob_pixels <= cfg_data[PixW-1:0];
                RegCooldownMs:     cfg_reg.cooldown_ms     <= cfg_data[WeightW-1:0];
                default: ;
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_blob_present_reg <= s_blob_present;
            in_near_depth_reg   <= s_near_depth;
            in_blob_pixels_reg  <= s_blob_pixels;
            in_now_ms_reg       <= s_now_ms;
        end
    end

    dpgd_update u_update (
        .cfg          (cfg_reg),
        .cur          (track_reg),
        .blob_present (in_blob_present_reg),
        .near_depth   (in_near_depth_reg),
        .blob_pixels  (in_blob_pixels_reg),
        .now_ms       (in_now_ms_reg),
        .nxt          (track_next),
        .res          (res_next)
    );

    // Tracker state and result register advance together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_reg.baseline      <= '0;
            track_reg.seeded        <= 1'b0;
            track_reg.armed         <= 1'b1;
            track_reg.click_total   <= '0;
            track_reg.last_click_ms <= '0;
            out_valid_reg           <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                track_reg <= track_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_clicked       = res_reg.clicked;
    assign m_push_delta    = $signed(res_reg.push_delta);
    assign m_is_armed      = res_reg.is_armed;
    assign m_clicks_so_far = res_reg.clicks_so_far;

endmodule : depth_push_gesture_detector_unit
`default_nettype wire
